// ===== rtl/core/cbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    localparam int LEVEL_W = 5;
    localparam int MODE_W  = 4;
    localparam int ADD_W   = LEVEL_W + 1;
    localparam int NUM_W   = 2 * LEVEL_W;
    localparam int DEN_W   = LEVEL_W + 1;
    localparam int REM_W   = LEVEL_W + 1;
    localparam int PROD_W  = ADD_W + LEVEL_W;
    localparam int SUM_W   = NUM_W + 1;

    // one divider cell per quotient bit
    localparam int NUM_CELLS = NUM_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 5'd31;
    localparam logic [DEN_W-1:0]   LEVEL_SPAN = 6'd32;
    localparam logic [DEN_W-1:0]   LEVEL_TOP  = 6'd31;

    typedef enum logic [MODE_W-1:0] {
        MODE_LIGHTEN    = 4'd0,
        MODE_SCREEN     = 4'd1,
        MODE_COLORDODGE = 4'd2,
        MODE_DODGEBURN  = 4'd3,
        MODE_DIFFERENCE = 4'd4,
        MODE_LIGHT      = 4'd5,
        MODE_SOFTSCREEN = 4'd6,
        MODE_ADD        = 4'd7,
        MODE_MULTIPLY   = 4'd8
    } t_blend_mode;

    // one beat in flight: result = add + num / den, clamped
    typedef struct packed {
        logic [ADD_W-1:0] add;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] quo;
    } t_beat;

endpackage

`default_nettype wire

// ===== rtl/core/cbm_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbm_prep (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [cbm_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [cbm_pkg::LEVEL_W-1:0] i_source_level,
    input  wire logic [cbm_pkg::LEVEL_W-1:0] i_base_level,
    output logic                             o_valid,
    output cbm_pkg::t_beat                   o_beat
);
    import cbm_pkg::*;

    logic [LEVEL_W-1:0] mx;
    logic [LEVEL_W-1:0] mn;
    logic [ADD_W-1:0]   op_a;
    logic [LEVEL_W-1:0] op_b;
    logic [PROD_W-1:0]  prod;
    logic [ADD_W-1:0]   add_term;
    logic [DEN_W-1:0]   den;
    logic [ADD_W-1:0]   src_x;
    logic [ADD_W-1:0]   base_x;
    logic [ADD_W-1:0]   mx_x;
    logic [ADD_W-1:0]   mn_x;
    t_beat              n_beat;
    logic               r_valid;
    t_beat              r_beat;

    assign mx     = (i_source_level > i_base_level) ? i_source_level : i_base_level;
    assign mn     = (i_source_level > i_base_level) ? i_base_level : i_source_level;
    assign src_x  = {1'b0, i_source_level};
    assign base_x = {1'b0, i_base_level};
    assign mx_x   = {1'b0, mx};
    assign mn_x   = {1'b0, mn};

    // one shared multiplier, operands picked by mode
    always_comb begin
        op_a     = '0;
        op_b     = '0;
        add_term = '0;
        den      = LEVEL_SPAN;
        unique case (i_mode)
            MODE_LIGHTEN: begin
                add_term = mx_x;
            end
            MODE_SCREEN: begin
                op_a     = LEVEL_SPAN - mx_x;
                op_b     = mn;
                add_term = mx_x;
            end
            MODE_COLORDODGE: begin
                op_a = LEVEL_SPAN;
                op_b = i_source_level;
                den  = LEVEL_SPAN - base_x;
            end
            MODE_DODGEBURN: begin
                op_a = LEVEL_SPAN - base_x;
                op_b = i_source_level;
            end
            MODE_DIFFERENCE: begin
                add_term = mx_x - mn_x;
            end
            MODE_LIGHT: begin
                op_a     = LEVEL_TOP - mx_x;
                op_b     = mn;
                add_term = mx_x;
                den      = LEVEL_TOP;
            end
            MODE_SOFTSCREEN: begin
                op_a     = LEVEL_TOP - base_x;
                op_b     = i_source_level;
                add_term = base_x;
                den      = LEVEL_TOP;
            end
            MODE_ADD: begin
                add_term = src_x + base_x;
            end
            MODE_MULTIPLY: begin
                op_a = base_x;
                op_b = i_source_level;
                den  = LEVEL_TOP;
            end
            default: begin
                add_term = '0;
            end
        endcase
    end

    assign prod = {{LEVEL_W{1'b0}}, op_a} * {{ADD_W{1'b0}}, op_b};

    always_comb begin
        n_beat.add = add_term;
        n_beat.num = prod[NUM_W-1:0];
        n_beat.den = den;
        n_beat.rem = '0;
        n_beat.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

// ===== rtl/core/cbm_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbm_div_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire cbm_pkg::t_beat i_beat,
    output logic                o_valid,
    output cbm_pkg::t_beat      o_beat
);
    import cbm_pkg::*;

    logic [REM_W:0]   shifted;
    logic [REM_W:0]   diff;
    logic             q_bit;
    t_beat            n_beat;
    logic             r_valid;
    t_beat            r_beat;

    // restoring step: bring down the next dividend bit, subtract if it fits
    assign shifted = {i_beat.rem, i_beat.num[NUM_W-1]};
    assign q_bit   = (shifted >= {1'b0, i_beat.den});
    assign diff    = shifted - {1'b0, i_beat.den};

    always_comb begin
        n_beat     = i_beat;
        n_beat.num = {i_beat.num[NUM_W-2:0], 1'b0};
        n_beat.rem = q_bit ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        n_beat.quo = {i_beat.quo[NUM_W-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

`ifndef NO_ASSERTIONS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_beat.rem < r_beat.den))
        else $error("partial remainder not below divisor");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_beat.den != '0))
        else $error("zero divisor in divider chain");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/cbm_finish.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbm_finish (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire cbm_pkg::t_beat         i_beat,
    output logic                        o_strobe,
    output logic [cbm_pkg::LEVEL_W-1:0] o_level
);
    import cbm_pkg::*;

    logic [SUM_W-1:0]   sum;
    logic [LEVEL_W-1:0] n_level;
    logic               r_strobe;
    logic [LEVEL_W-1:0] r_level;

    assign sum     = {{(SUM_W-ADD_W){1'b0}}, i_beat.add} + {1'b0, i_beat.quo};
    assign n_level = (sum > {{(SUM_W-LEVEL_W){1'b0}}, LEVEL_MAX}) ? LEVEL_MAX
                                                                : sum[LEVEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= n_level;
    end

    assign o_strobe = r_strobe;
    assign o_level  = r_level;

endmodule

`default_nettype wire

// ===== rtl/core/channel_blend_mode_unit_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: the operand stage, the divider chain and the clamp stage, each registered.
// Throughput: one beat per cycle; busy is low whenever reset is released.
// The divider chain holds one cell per quotient bit, 10 cells, between the
// operand stage and the clamp stage.
// Reset (synchronous, active low) clears the mode to lighten and empties the chain.
// The receiver cannot stall: o_strobe marks each result for exactly one cycle.
module channel_blend_mode_unit_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [cbm_pkg::LEVEL_W-1:0] i_source_level,
    input  wire logic [cbm_pkg::LEVEL_W-1:0] i_base_level,
    input  wire logic                        i_cfg_we,
    input  wire logic [cbm_pkg::MODE_W-1:0]  i_cfg_data,
    output logic                             o_strobe,
    output logic [cbm_pkg::LEVEL_W-1:0]      o_blended_level
);
    import cbm_pkg::*;

    logic              r_mode_we_seen;
    logic [MODE_W-1:0] r_mode;
    logic              w_accept;
    logic              s_valid [0:NUM_CELLS];
    t_beat             s_beat  [0:NUM_CELLS];

    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_LIGHTEN;
            r_mode_we_seen <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode         <= i_cfg_data;
            r_mode_we_seen <= 1'b1;
        end
    end

    cbm_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_accept),
        .i_mode         (r_mode),
        .i_source_level (i_source_level),
        .i_base_level   (i_base_level),
        .o_valid        (s_valid[0]),
        .o_beat         (s_beat[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        cbm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .i_beat  (s_beat[k]),
            .o_valid (s_valid[k+1]),
            .o_beat  (s_beat[k+1])
        );
    end

    cbm_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_valid[NUM_CELLS]),
        .i_beat   (s_beat[NUM_CELLS]),
        .o_strobe (o_strobe),
        .o_level  (o_blended_level)
    );

`ifndef NO_ASSERTIONS
    a_strobe_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, 12))
        else $error("result strobe without a matching accepted beat");

    a_chain_front_tracks_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (s_valid[0] == $past(w_accept)))
        else $error("operand stage valid out of step with accept");

    a_mode_held_without_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cfg_we)) |-> $stable(r_mode))
        else $error("mode changed without a write");

    a_write_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_mode_we_seen)
        else $error("mode write not recorded");
`endif

endmodule

`default_nettype wire
